>>> design/clamped_haze_scene_recovery_defines.svh
// Assertion macros shared by the scene recovery block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef CLAMPED_HAZE_SCENE_RECOVERY_DEFINES_SVH
`define CLAMPED_HAZE_SCENE_RECOVERY_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CHSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CHSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/chsr_pkg.sv
// Package for the clamped haze scene recovery block: register map, widths
// and shared types. No dependencies.
package chsr_pkg;

  // Configuration register width and index width
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_VEIL_CH0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEIL_CH1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEIL_CH2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T_MIN         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_T_MAX         = 3'd5;

  // Transmission clamp defaults, in percent of one
  localparam int TMIN_PCT = 10;
  localparam int TMAX_PCT = 95;

  // Number of color lanes
  localparam int NUM_LANES = 3;

  // Per-lane configuration
  typedef struct packed {
    logic [CFG_W-1:0] veil;
    logic             mode;
  } chsr_lane_cfg_t;

endpackage

>>> design/clamped_haze_scene_recovery.sv
// Top level of the clamped haze scene recovery block: config registers,
// transmission clamp, stage valid chain, three lanes and the merge stage.
// Depends on chsr_pkg, chsr_lane, chsr_merge and the defines header.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid_i/in_ready_o, pixel_ch*, trans_in | in
//   output  | out_valid_o/out_ready_i, out_ch*           | out
//   config  | cfg_we_i, cfg_idx_i, cfg_wdata_i           | in
//
// One pixel per cycle sustained while the output is not stalled; the divider yields
// one quotient bit per stage.
// Reset clears the stage valid bits and loads the config registers' reset values;
// there is no clearing pass. On an output stall, stages fill in order from the output;
// bubbles are squeezed out, so a new pixel is taken as long as the first stage is free.
`include "clamped_haze_scene_recovery_defines.svh"

module clamped_haze_scene_recovery
  import chsr_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [FRAC_BITS:0]          pixel_ch0_i,
  input  logic [FRAC_BITS:0]          pixel_ch1_i,
  input  logic [FRAC_BITS:0]          pixel_ch2_i,
  input  logic [FRAC_BITS:0]          trans_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FRAC_BITS+1:0] out_ch0_o,
  output logic signed [FRAC_BITS+1:0] out_ch1_o,
  output logic signed [FRAC_BITS+1:0] out_ch2_o
);

  localparam int IN_W      = FRAC_BITS + 1;
  localparam int OUT_W     = FRAC_BITS + 2;
  localparam int VW        = (IN_W > CFG_W) ? IN_W : CFG_W;
  localparam int QW        = VW + FRAC_BITS;
  localparam int LAT       = QW + 3;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int T_MIN_RST = (ONE * TMIN_PCT + 50) / 100;
  localparam int T_MAX_RST = (ONE * TMAX_PCT + 50) / 100;

  // Configuration registers
  logic [CFG_W-1:0] veil_q [NUM_LANES];
  logic             mode_q;
  logic [VW-1:0]    t_min_q;
  logic [VW-1:0]    t_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      veil_q[0] <= '0;
      veil_q[1] <= '0;
      veil_q[2] <= '0;
      mode_q    <= 1'b0;
      t_min_q   <= VW'(T_MIN_RST);
      t_max_q   <= VW'(T_MAX_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VEIL_CH0:      veil_q[0] <= cfg_wdata_i;
        REG_VEIL_CH1:      veil_q[1] <= cfg_wdata_i;
        REG_VEIL_CH2:      veil_q[2] <= cfg_wdata_i;
        REG_RECOVERY_MODE: mode_q    <= cfg_wdata_i[0];
        REG_T_MIN:         t_min_q   <= VW'(cfg_wdata_i);
        REG_T_MAX:         t_max_q   <= VW'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Clamp the transmission: lower bound first, then upper, never zero
  logic [VW-1:0] t_lo;
  logic [VW-1:0] t_hi;
  logic [VW-1:0] t_clamp;

  always_comb begin
    t_lo    = (VW'(trans_in_i) < t_min_q) ? t_min_q : VW'(trans_in_i);
    t_hi    = (t_lo > t_max_q) ? t_max_q : t_lo;
    t_clamp = (t_hi == '0) ? VW'(1) : t_hi;
  end

  // Stage valid chain; a stage loads when it is empty or its successor loads
  logic [LAT-1:0] v_q;
  logic [LAT-1:0] v_d;
  logic [LAT:0]   rdy;
  logic           mrg_ready;

  always_comb begin
    rdy[LAT] = mrg_ready;
    for (int k = LAT - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d = v_q;
    if (rdy[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < LAT; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = rdy[0];

  // Lanes
  logic [IN_W-1:0]         pix [NUM_LANES];
  logic signed [OUT_W-1:0] lane_res [NUM_LANES];
  chsr_lane_cfg_t          lane_cfg [NUM_LANES];

  assign pix[0] = pixel_ch0_i;
  assign pix[1] = pixel_ch1_i;
  assign pix[2] = pixel_ch2_i;

  for (genvar gl = 0; gl < NUM_LANES; gl++) begin : g_lane
    assign lane_cfg[gl] = '{veil: veil_q[gl], mode: mode_q};

    chsr_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .pix_i (pix[gl]),
      .t_i   (t_clamp),
      .cfg_i (lane_cfg[gl]),
      .en_i  (rdy[LAT-1:0]),
      .res_o (lane_res[gl])
    );
  end

  // Merge the lane results into the output register
  chsr_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lane_valid_i (v_q[LAT-1]),
    .lane_res_i   (lane_res),
    .lane_ready_o (mrg_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_ch0_o    (out_ch0_o),
    .out_ch1_o    (out_ch1_o),
    .out_ch2_o    (out_ch2_o)
  );

  // A finished pixel in the last stage survives an output stall
  `CHSR_ASSERT_NEXT(a_last_held, v_q[LAT-1] && out_valid_o && !out_ready_i, v_q[LAT-1], "last stage lost during stall")
  // Input backpressure only when every stage and the output are full
  `CHSR_ASSERT_NOW(a_full_stall, !in_ready_o, (&v_q) && out_valid_o && !out_ready_i, "stall with a bubble in the pipe")
  // An empty output register never blocks the input
  `CHSR_ASSERT_NOW(a_empty_ready, !out_valid_o, in_ready_o, "input blocked with output empty")

endmodule

>>> design/chsr_lane.sv
// One color lane: sign/magnitude prep, pipelined restoring divider (one
// quotient bit per stage), quotient clamp, offset add and saturation.
// Depends on chsr_pkg.
module chsr_lane
  import chsr_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                      clk_i,
  input  logic [FRAC_BITS:0]        pix_i,
  input  logic [((FRAC_BITS+1 > CFG_W) ? FRAC_BITS+1 : CFG_W)-1:0] t_i,
  input  chsr_lane_cfg_t            cfg_i,
  input  logic [((FRAC_BITS+1 > CFG_W) ? FRAC_BITS+1 : CFG_W)+FRAC_BITS+2:0] en_i,
  output logic signed [FRAC_BITS+1:0] res_o
);

  localparam int IN_W  = FRAC_BITS + 1;
  localparam int OUT_W = FRAC_BITS + 2;
  localparam int VW    = (IN_W > CFG_W) ? IN_W : CFG_W;
  localparam int QW    = VW + FRAC_BITS;
  localparam int QCW   = VW + 2;
  localparam int OMW   = VW + 2;
  localparam int PW    = CFG_W + 1 + OMW;
  localparam int SW    = PW + 1;
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int FIX   = QW + 1;
  localparam int RES   = QW + 2;

  // Divider pipeline: stage 0 is the load stage, stage i yields quotient bit QW-i
  logic [QW-1:0] num_q [QW+1];
  logic [VW-1:0] rem_q [QW+1];
  logic [VW-1:0] div_q [QW+1];
  logic          neg_q [QW+1];

  logic [VW-1:0] pix_ext;
  logic [VW-1:0] veil_ext;
  logic          neg_d;
  logic [VW-1:0] mag_d;

  // Split the difference into sign and magnitude
  always_comb begin
    pix_ext  = VW'(pix_i);
    veil_ext = VW'(cfg_i.veil);
    neg_d    = pix_ext < veil_ext;
    mag_d    = neg_d ? (veil_ext - pix_ext) : (pix_ext - veil_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num_q[0] <= {mag_d, {FRAC_BITS{1'b0}}};
      rem_q[0] <= '0;
      div_q[0] <= t_i;
      neg_q[0] <= neg_d;
    end
  end

  // One restoring step per stage
  for (genvar gi = 1; gi <= QW; gi++) begin : g_div
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[gi-1], num_q[gi-1][QW-1]};
      diff  = trial - {1'b0, div_q[gi-1]};
      ge    = trial >= {1'b0, div_q[gi-1]};
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[gi]) begin
        num_q[gi] <= {num_q[gi-1][QW-2:0], ge};
        rem_q[gi] <= rem_d;
        div_q[gi] <= div_q[gi-1];
        neg_q[gi] <= neg_q[gi-1];
      end
    end
  end

  // Offset from the veil, refreshed every cycle from the config register
  logic signed [CFG_W:0]  a_s;
  logic signed [OMW-1:0]  om_s;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   prod_adj;
  logic signed [PW-1:0]   off_d;
  logic signed [PW-1:0]   off_q;

  always_comb begin
    a_s      = $signed({1'b0, cfg_i.veil});
    om_s     = $signed(OMW'(ONE)) - $signed(OMW'(cfg_i.veil));
    prod     = a_s * om_s;
    // Truncate toward zero on the shift
    prod_adj = prod + (prod[PW-1] ? $signed(PW'(ONE - 1)) : $signed(PW'(0)));
    off_d    = cfg_i.mode ? (prod_adj >>> FRAC_BITS) : PW'(a_s);
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
  end

  // Apply the sign and clamp the quotient to [-A, ONE - A]
  logic signed [QW:0]    q_s;
  logic signed [QW:0]    lo_s;
  logic signed [QW:0]    hi_s;
  logic signed [QW:0]    q_lo;
  logic signed [QW:0]    q_hi;
  logic signed [QCW-1:0] q_q;

  always_comb begin
    q_s  = neg_q[QW] ? -$signed({1'b0, num_q[QW]}) : $signed({1'b0, num_q[QW]});
    lo_s = -$signed((QW+1)'(cfg_i.veil));
    hi_s = $signed((QW+1)'(ONE)) - $signed((QW+1)'(cfg_i.veil));
    q_lo = (q_s < lo_s) ? lo_s : q_s;
    q_hi = (q_lo > hi_s) ? hi_s : q_lo;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[FIX]) begin
      q_q <= QCW'(q_hi);
    end
  end

  // Add the offset and saturate to [-ONE, ONE]
  logic signed [SW-1:0]    sum;
  logic signed [SW-1:0]    sat;
  logic signed [OUT_W-1:0] res_q;

  always_comb begin
    sum = SW'(q_q) + SW'(off_q);
    if (sum > $signed(SW'(ONE))) begin
      sat = $signed(SW'(ONE));
    end else if (sum < -$signed(SW'(ONE))) begin
      sat = -$signed(SW'(ONE));
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[RES]) begin
      res_q <= OUT_W'(sat);
    end
  end

  assign res_o = res_q;

endmodule

>>> design/chsr_merge.sv
// Merge stage: gathers the three lane results into one output register
// with its valid/ready handshake. Depends on chsr_pkg.
module chsr_merge
  import chsr_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        lane_valid_i,
  input  logic signed [FRAC_BITS+1:0] lane_res_i [NUM_LANES],
  output logic                        lane_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FRAC_BITS+1:0] out_ch0_o,
  output logic signed [FRAC_BITS+1:0] out_ch1_o,
  output logic signed [FRAC_BITS+1:0] out_ch2_o
);

  localparam int OUT_W = FRAC_BITS + 2;

  logic                    out_valid_q;
  logic                    out_valid_d;
  logic signed [OUT_W-1:0] ch_q [NUM_LANES];

  // Take a new result when the register is empty or being drained
  assign lane_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_d  = lane_ready_o ? lane_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload while the transfer waits
  always_ff @(posedge clk_i) begin
    if (lane_ready_o && lane_valid_i) begin
      ch_q <= lane_res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ch0_o   = ch_q[0];
  assign out_ch1_o   = ch_q[1];
  assign out_ch2_o   = ch_q[2];

endmodule

>>> tb/sv/clamped_haze_scene_recovery_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for clamped_haze_scene_recovery: directed and random
// pixels under several veil and clamp settings. Depends on chsr_pkg and the RTL.
module clamped_haze_scene_recovery_test
  import chsr_pkg::*;
;

  localparam int FRAC_BITS = 12;
  localparam int IN_W = FRAC_BITS + 1;
  localparam int OUT_W = FRAC_BITS + 2;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int FLOW_LATENCY = CFG_W + FRAC_BITS + 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AFTER = 500;
  localparam int RANDOM_SCENES = 8;
  localparam int PIXELS_PER_SCENE = 185;

  // Indexes outside the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [IN_W-1:0] ch0;
    logic [IN_W-1:0] ch1;
    logic [IN_W-1:0] ch2;
    logic [IN_W-1:0] trans;
  } hazy_px_t;

  typedef struct packed {
    logic [OUT_W-1:0] ch0;
    logic [OUT_W-1:0] ch1;
    logic [OUT_W-1:0] ch2;
  } scene_px_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [IN_W-1:0]         pixel_ch0_i = '0;
  logic [IN_W-1:0]         pixel_ch1_i = '0;
  logic [IN_W-1:0]         pixel_ch2_i = '0;
  logic [IN_W-1:0]         trans_in_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] out_ch0_o;
  logic signed [OUT_W-1:0] out_ch1_o;
  logic signed [OUT_W-1:0] out_ch2_o;

  // Local copy of the register file, starting at its reset values
  logic [CFG_W-1:0] veil_lvl [NUM_LANES] = '{default: '0};
  logic             mode_bit = 1'b0;
  logic [CFG_W-1:0] t_floor = CFG_W'((ONE * TMIN_PCT + 50) / 100);
  logic [CFG_W-1:0] t_ceil = CFG_W'((ONE * TMAX_PCT + 50) / 100);

  hazy_px_t  hazy_pixel_q[$];
  scene_px_t recovered_q[$];
  hazy_px_t  next_px;
  hazy_px_t  taken_px;
  scene_px_t want;

  int mismatch_count = 0;
  int pixels_checked = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  clamped_haze_scene_recovery #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_ch0_i(pixel_ch0_i),
    .pixel_ch1_i(pixel_ch1_i),
    .pixel_ch2_i(pixel_ch2_i),
    .trans_in_i (trans_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_ch0_o  (out_ch0_o),
    .out_ch1_o  (out_ch1_o),
    .out_ch2_o  (out_ch2_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One lane: scale the haze-free difference by 1/t, bound it, add the offset back
  function automatic logic [OUT_W-1:0] recover_lane(longint pix, longint veil, longint t);
    longint q;
    longint off;
    longint r;
    q = ((pix - veil) * ONE) / t;
    if (q < -veil) q = -veil;
    if (q > ONE - veil) q = ONE - veil;
    off = mode_bit ? (veil * (ONE - veil)) / ONE : veil;
    r = q + off;
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return r[OUT_W-1:0];
  endfunction

  // Lower clamp first, then upper, so an inverted pair settles on t_ceil
  function automatic scene_px_t recover_pixel(hazy_px_t px);
    longint t;
    scene_px_t r;
    t = px.trans;
    if (t < longint'(t_floor)) t = t_floor;
    if (t > longint'(t_ceil)) t = t_ceil;
    if (t < 1) t = 1;
    r.ch0 = recover_lane(px.ch0, veil_lvl[0], t);
    r.ch1 = recover_lane(px.ch1, veil_lvl[1], t);
    r.ch2 = recover_lane(px.ch2, veil_lvl[2], t);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int pick_gap(inout int calm);
    int roll;
    roll = $urandom_range(99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 5) begin
      calm = $urandom_range(80, 20);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [IN_W-1:0] pick_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    if (roll < 30) return IN_W'(ONE);
    if (roll < 35) return IN_W'(ONE - 1);
    return IN_W'($urandom_range(ONE));
  endfunction

  // Favor the clamp edges so both bounds get hit from either side
  function automatic logic [IN_W-1:0] pick_trans();
    int roll;
    int t;
    roll = $urandom_range(99);
    if (roll < 10) t = 0;
    else if (roll < 20) t = ONE;
    else if (roll < 35) t = int'(t_floor) + int'($urandom_range(4)) - 2;
    else if (roll < 45) t = int'(t_ceil) + int'($urandom_range(4)) - 2;
    else t = $urandom_range(ONE);
    if (t < 0) t = 0;
    if (t > ONE) t = ONE;
    return t[IN_W-1:0];
  endfunction

  function automatic void compare_lane(int lane, logic [OUT_W-1:0] exp_v,
                                       logic [OUT_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: out_ch%0d expected %0d, got %0d", $time, lane,
               $signed(exp_v), $signed(got_v));
      mismatch_count++;
    end
  endfunction

  task automatic offer_pixel(int p0, int p1, int p2, int t);
    hazy_px_t px;
    px.ch0 = p0[IN_W-1:0];
    px.ch1 = p1[IN_W-1:0];
    px.ch2 = p2[IN_W-1:0];
    px.trans = t[IN_W-1:0];
    hazy_pixel_q.push_back(px);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    unique case (idx)
      REG_VEIL_CH0: veil_lvl[0] = data;
      REG_VEIL_CH1: veil_lvl[1] = data;
      REG_VEIL_CH2: veil_lvl[2] = data;
      REG_RECOVERY_MODE: mode_bit = data[0];
      REG_T_MIN: t_floor = data;
      REG_T_MAX: t_ceil = data;
      default: ;
    endcase
  endtask

  // Write the full register set, then release the port
  task automatic program_scene(int v0, int v1, int v2, int mode_word, int tlo, int thi);
    write_reg(REG_VEIL_CH0, v0[CFG_W-1:0]);
    write_reg(REG_VEIL_CH1, v1[CFG_W-1:0]);
    write_reg(REG_VEIL_CH2, v2[CFG_W-1:0]);
    write_reg(REG_RECOVERY_MODE, mode_word[CFG_W-1:0]);
    write_reg(REG_T_MIN, tlo[CFG_W-1:0]);
    write_reg(REG_T_MAX, thi[CFG_W-1:0]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold until every queued pixel went in and every result came back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (hazy_pixel_q.size() != 0 || in_valid_i || recovered_q.size() != 0);
  endtask

  // Input driver: present the next queued pixel once the previous one transferred
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (hazy_pixel_q.size() != 0) begin
        next_px = hazy_pixel_q.pop_front();
        pixel_ch0_i <= next_px.ch0;
        pixel_ch1_i <= next_px.ch1;
        pixel_ch2_i <= next_px.ch2;
        trans_in_i <= next_px.trans;
        in_valid_i <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check result transfers, predict input transfers, drive out_ready_i
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (recovered_q.size() == 0) begin
          $display("%0t ns: result with no pixel outstanding: %0d %0d %0d", $time,
                   out_ch0_o, out_ch1_o, out_ch2_o);
          mismatch_count++;
        end else begin
          want = recovered_q.pop_front();
          compare_lane(0, want.ch0, out_ch0_o);
          compare_lane(1, want.ch1, out_ch1_o);
          compare_lane(2, want.ch2, out_ch2_o);
          pixels_checked++;
        end
      end

      if (in_valid_i && in_ready_o) begin
        taken_px.ch0 = pixel_ch0_i;
        taken_px.ch1 = pixel_ch1_i;
        taken_px.ch2 = pixel_ch2_i;
        taken_px.trans = trans_in_i;
        recovered_q.push_back(recover_pixel(taken_px));
      end

      // One long hold-off so the pipeline fills and backs up into the input
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && pixels_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("clamped_haze_scene_recovery regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int floor_pick;
    int ceil_pick;
    int roll;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: zero veil, default clamps, both clamp edges
    offer_pixel(0, 0, 0, 0);
    offer_pixel(4096, 4096, 4096, 4096);
    offer_pixel(4096, 0, 2048, 409);
    offer_pixel(4096, 4096, 4096, 410);
    offer_pixel(1, 2, 3, 3891);
    offer_pixel(4095, 100, 4096, 3892);
    offer_pixel(0, 4096, 1, 1);
    wait_idle();

    // Unmapped writes are dropped; mode takes only bit 0 of the word
    write_reg(REG_SPARE_LO, 13'h1FFF);
    write_reg(REG_SPARE_HI, 13'h0AAA);
    program_scene(2048, 4096, 0, 13'h1FFF, 1, 4096);
    offer_pixel(0, 0, 0, 0);
    offer_pixel(4096, 4096, 4096, 0);
    offer_pixel(2047, 4095, 4096, 4096);
    offer_pixel(2049, 0, 1, 1);
    offer_pixel(4096, 2048, 0, 2);
    wait_idle();

    // Zero transmission: floor of zero with a zero estimate
    program_scene(1000, 3000, 4096, 0, 0, 4096);
    offer_pixel(0, 4096, 2000, 0);
    offer_pixel(2000, 1000, 0, 0);
    wait_idle();

    // Zero transmission: ceiling written as zero
    program_scene(1000, 3000, 4096, 0, 410, 0);
    offer_pixel(4096, 0, 4096, 4096);
    offer_pixel(0, 4096, 123, 1000);
    wait_idle();

    // Inverted clamp: floor above ceiling
    program_scene(512, 1024, 3584, 1, 3000, 1000);
    offer_pixel(4096, 0, 2000, 0);
    offer_pixel(0, 4096, 1000, 2000);
    offer_pixel(1234, 567, 4000, 4096);
    wait_idle();

    // Veil above one, in both modes; in mode 1 the negative offset saturates the output
    program_scene(8191, 5000, 4097, 1, 1, 4096);
    offer_pixel(0, 4096, 4096, 4096);
    offer_pixel(4096, 0, 0, 1);
    wait_idle();
    program_scene(8191, 5000, 4097, 0, 1, 4096);
    offer_pixel(2048, 4096, 4096, 2048);
    wait_idle();

    // Random scenes, each drained before the registers change
    for (int scene = 0; scene < RANDOM_SCENES; scene++) begin
      roll = $urandom_range(99);
      if (roll < 20) floor_pick = 1;
      else if (roll < 30) floor_pick = ONE;
      else floor_pick = $urandom_range(ONE / 2, 1);
      roll = $urandom_range(99);
      if (roll < 25) ceil_pick = ONE;
      else if (roll < 35) ceil_pick = $urandom_range(ONE, 1);
      else ceil_pick = $urandom_range(ONE, floor_pick);
      program_scene(pick_level(), pick_level(), pick_level(), $urandom_range(1),
                    floor_pick, ceil_pick);
      repeat (PIXELS_PER_SCENE)
        offer_pixel(pick_level(), pick_level(), pick_level(), pick_trans());
      wait_idle();
    end

    repeat (FLOW_LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("clamped_haze_scene_recovery regression: pass");
    else
      $display("clamped_haze_scene_recovery regression: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/chsr_pkg.sv
design/chsr_lane.sv
design/chsr_merge.sv
design/clamped_haze_scene_recovery.sv
tb/sv/clamped_haze_scene_recovery_test.sv
